### hdl/coupled_fiala_tire_force_macros.svh
`ifndef COUPLED_FIALA_TIRE_FORCE_MACROS_SVH
`define COUPLED_FIALA_TIRE_FORCE_MACROS_SVH

// checked on every clock edge outside reset
`define CFT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every clock edge, reset included
`define CFT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hdl/cft_pkg.sv
package cft_pkg;

   typedef enum logic [1:0] {
      REG_CORNER   = 2'd0,
      REG_MU_PEAK  = 2'd1,
      REG_MU_SLIDE = 2'd2
   } reg_index_type;

   localparam int IN_TDATA_W  = 56;
   localparam int OUT_TDATA_W = 40;
   localparam int CSR_W       = 20;

   localparam logic [19:0] CORNER_RESET   = 20'd100000;
   localparam logic [9:0]  MU_PEAK_RESET  = 10'd256;
   localparam logic [9:0]  MU_SLIDE_RESET = 10'd256;

   localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
   localparam logic [19:0] FORCE_MAX = 20'hF_FFFF;

   localparam int SIN_STEPS = 5;
   localparam int COS_STEPS = 6;
   localparam int SIN_DEN [SIN_STEPS] = '{110, 72, 42, 20, 6};
   localparam int COS_DEN [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

endpackage

### hdl/cft_delay.sv
module cft_delay #(
   parameter int W = 8,
   parameter int N = 2
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);
   logic [W-1:0] pipe_ff [N];

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= din;
         for (int k = 1; k < N; k++) begin
            pipe_ff[k] <= pipe_ff[k-1];
         end
      end
   end

   assign dout = pipe_ff[N-1];
endmodule

### hdl/cft_div.sv
module cft_div #(
   parameter int NW = 44,
   parameter int DW = 29,
   parameter int QW = 16
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic [QW-1:0] quotient
);
   localparam int CW = (NW > DW + QW) ? NW : DW + QW;

   logic [NW-1:0] rem_ff [QW-1];
   logic [DW-1:0] d_ff   [QW-1];
   logic [QW-1:0] q_ff   [QW-1];
   logic [QW-1:0] quot_ff;

   for (genvar j = 0; j < QW; j++) begin : g_stage
      localparam int SH = QW - 1 - j;
      logic [NW-1:0] rem_cur;
      logic [DW-1:0] d_cur;
      logic [QW-1:0] q_cur;
      logic [CW-1:0] trial;
      logic          take;

      if (j == 0) begin : g_first
         assign rem_cur = dividend;
         assign d_cur   = divisor;
         assign q_cur   = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[j-1];
         assign d_cur   = d_ff[j-1];
         assign q_cur   = q_ff[j-1];
      end

      assign trial = CW'(d_cur) << SH;
      assign take  = CW'(rem_cur) >= trial;

      if (j < QW - 1) begin : g_reg
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= take ? NW'(CW'(rem_cur) - trial) : rem_cur;
               d_ff[j]   <= d_cur;
               q_ff[j]   <= take ? (q_cur | (QW'(1) << SH)) : q_cur;
            end
         end
      end else begin : g_last
         always_ff @(posedge clock) begin
            if (en) begin
               quot_ff <= take ? (q_cur | (QW'(1) << SH)) : q_cur;
            end
         end
      end
   end

   assign quotient = quot_ff;
endmodule

### hdl/cft_sqrt.sv
module cft_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [32:0] radicand,
   output logic [16:0] root
);
   localparam int NS = 17;

   logic [32:0] rem_ff  [NS-1];
   logic [16:0] part_ff [NS-1];
   logic [16:0] root_ff;

   for (genvar j = 0; j < NS; j++) begin : g_stage
      localparam int B = NS - 1 - j;
      logic [32:0] rem_cur;
      logic [16:0] part_cur;
      logic [34:0] cand;
      logic        take;

      if (j == 0) begin : g_first
         assign rem_cur  = radicand;
         assign part_cur = '0;
      end else begin : g_next
         assign rem_cur  = rem_ff[j-1];
         assign part_cur = part_ff[j-1];
      end

      assign cand = (35'(part_cur) << (B + 1)) | (35'(1) << (2 * B));
      assign take = 35'(rem_cur) >= cand;

      if (j < NS - 1) begin : g_reg
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j]  <= take ? 33'(35'(rem_cur) - cand) : rem_cur;
               part_ff[j] <= take ? (part_cur | (17'(1) << B)) : part_cur;
            end
         end
      end else begin : g_last
         always_ff @(posedge clock) begin
            if (en) begin
               root_ff <= take ? (part_cur | (17'(1) << B)) : part_cur;
            end
         end
      end
   end

   assign root = root_ff;
endmodule

### hdl/cft_hstep.sv
module cft_hstep #(
   parameter int K = 6
) (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] h_in,
   input  logic [30:0] x2_in,
   output logic [30:0] h_out,
   output logic [30:0] x2_out
);
   import cft_pkg::*;

   localparam logic [31:0] RCP = 32'((64'd1 << 32) / K);

   logic [30:0] va_ff, vb_ff, q0_ff, h_ff;
   logic [30:0] x2a_ff, x2b_ff, x2c_ff;
   logic [61:0] prod;
   logic [62:0] scaled;
   logic [30:0] resid;
   logic [30:0] quot;

   assign prod   = x2_in * h_in;
   assign scaled = va_ff * RCP;
   assign resid  = vb_ff - 31'(q0_ff * 31'(K));
   assign quot   = (resid >= 31'(K)) ? q0_ff + 31'd1 : q0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         va_ff  <= 31'(prod >> 30);
         x2a_ff <= x2_in;
         q0_ff  <= 31'(scaled >> 32);
         vb_ff  <= va_ff;
         x2b_ff <= x2a_ff;
         h_ff   <= ONE_Q30 - quot;
         x2c_ff <= x2b_ff;
      end
   end

   assign h_out  = h_ff;
   assign x2_out = x2c_ff;
endmodule

### hdl/coupled_fiala_tire_force.sv
// channel   direction  transaction
// req_      in         slip_angle, long_force, normal_load
// rsp_      out        lateral_force, derating_factor
// csr_      in         register write, no read-back
//
// one transaction enters per cycle while no result is stalled; the path to each result runs
// through the three pipelined dividers, the square root and the horner steps
// reset is synchronous: it clears the valid bits and loads register defaults
// a stalled result freezes the whole pipeline; req_tready falls only then
module coupled_fiala_tire_force (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // slip_angle[15:0], long_force[35:16], normal_load[54:36]
   input  logic [cft_pkg::IN_TDATA_W-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // lateral_force[20:0], derating_factor[37:21]
   output logic [cft_pkg::OUT_TDATA_W-1:0] rsp_tdata,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_index,
   input  logic [cft_pkg::CSR_W-1:0]       csr_wdata
);
   import cft_pkg::*;

   localparam int LAT = 68;

   typedef struct packed {
      logic        aneg;
      logic        azero;
      logic [18:0] fz;
      logic [28:0] m;
   } side1_type;

   typedef struct packed {
      logic        grip;
      logic        aneg;
      logic        azero;
      logic [16:0] z;
      logic [35:0] zf;
   } side2_type;

   logic [19:0] corner_ff;
   logic [9:0]  mu_peak_ff, mu_slide_ff;
   logic [LAT-1:0] vld_ff;
   logic        en;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff   <= CORNER_RESET;
         mu_peak_ff  <= MU_PEAK_RESET;
         mu_slide_ff <= MU_SLIDE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_CORNER:   corner_ff   <= csr_wdata;
            REG_MU_PEAK:  mu_peak_ff  <= csr_wdata[9:0];
            REG_MU_SLIDE: mu_slide_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // stage 0: magnitudes
   logic [15:0] slip;
   logic [19:0] lfx;
   logic [15:0] amag0_ff;
   logic        aneg0_ff;
   logic [19:0] fxm0_ff;
   logic [18:0] fz0_ff;

   assign slip = req_tdata[15:0];
   assign lfx  = req_tdata[35:16];

   // stage 1: friction budget and angle square
   logic [28:0] m1_ff;
   logic [27:0] f1_ff;
   logic [30:0] x21_ff;
   logic [15:0] amag1_ff;
   logic        aneg1_ff, azero1_ff;
   logic [18:0] fz1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         amag0_ff  <= slip[15] ? 16'(~slip + 16'd1) : slip;
         aneg0_ff  <= slip[15];
         fxm0_ff   <= lfx[19] ? 20'(~lfx + 20'd1) : lfx;
         fz0_ff    <= req_tdata[54:36];
         m1_ff     <= 29'(mu_peak_ff * fz0_ff);
         f1_ff     <= {fxm0_ff, 8'd0};
         x21_ff    <= 31'(amag0_ff * amag0_ff);
         amag1_ff  <= amag0_ff;
         aneg1_ff  <= aneg0_ff;
         azero1_ff <= (amag0_ff == 16'd0);
         fz1_ff    <= fz0_ff;
      end
   end

   // derating factor
   logic [15:0] t17;
   logic        gt1, gt17;
   logic [32:0] v18_ff;
   logic [16:0] z35, z45;

   assign gt1 = m1_ff > {1'b0, f1_ff};

   cft_div #(.NW(44), .DW(29), .QW(16)) u_div_ratio (
      .clock(clock), .en(en), .dividend({f1_ff, 16'd0}), .divisor(m1_ff),
      .quotient(t17)
   );

   cft_delay #(.W(1), .N(16)) u_dly_gt (
      .clock(clock), .en(en), .din(gt1), .dout(gt17)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         v18_ff <= gt17 ? 33'(33'h1_0000_0000 - 33'(t17 * t17)) : 33'd0;
      end
   end

   cft_sqrt u_sqrt (
      .clock(clock), .en(en), .radicand(v18_ff), .root(z35)
   );

   cft_delay #(.W(17), .N(10)) u_dly_z (
      .clock(clock), .en(en), .din(z35), .dout(z45)
   );

   // tangent of slip angle
   logic [30:0] hs [SIN_STEPS+1];
   logic [30:0] xs [SIN_STEPS];
   logic [30:0] hc [COS_STEPS+1];
   logic [30:0] xc [COS_STEPS];

   assign hs[0] = ONE_Q30;
   assign xs[0] = x21_ff;
   assign hc[0] = ONE_Q30;
   assign xc[0] = x21_ff;

   for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
      if (i < SIN_STEPS - 1) begin : g_mid
         cft_hstep #(.K(SIN_DEN[i])) u_step (
            .clock(clock), .en(en), .h_in(hs[i]), .x2_in(xs[i]),
            .h_out(hs[i+1]), .x2_out(xs[i+1])
         );
      end else begin : g_end
         cft_hstep #(.K(SIN_DEN[i])) u_step (
            .clock(clock), .en(en), .h_in(hs[i]), .x2_in(xs[i]),
            .h_out(hs[i+1]), .x2_out()
         );
      end
   end

   for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
      if (i < COS_STEPS - 1) begin : g_mid
         cft_hstep #(.K(COS_DEN[i])) u_step (
            .clock(clock), .en(en), .h_in(hc[i]), .x2_in(xc[i]),
            .h_out(hc[i+1]), .x2_out(xc[i+1])
         );
      end else begin : g_end
         cft_hstep #(.K(COS_DEN[i])) u_step (
            .clock(clock), .en(en), .h_in(hc[i]), .x2_in(xc[i]),
            .h_out(hc[i+1]), .x2_out()
         );
      end
   end

   logic [15:0] amag16;
   logic [30:0] sv17_ff, sv19, cv19;
   logic [25:0] tan45;

   cft_delay #(.W(16), .N(15)) u_dly_amag (
      .clock(clock), .en(en), .din(amag1_ff), .dout(amag16)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sv17_ff <= 31'((47'(amag16) * 47'(hs[SIN_STEPS])) >> 15);
      end
   end

   cft_delay #(.W(31), .N(2)) u_dly_sin (
      .clock(clock), .en(en), .din(sv17_ff), .dout(sv19)
   );

   assign cv19 = (hc[COS_STEPS] == 31'd0) ? 31'd1 : hc[COS_STEPS];

   cft_div #(.NW(55), .DW(31), .QW(26)) u_div_tan (
      .clock(clock), .en(en), .dividend({sv19, 24'd0}), .divisor(cv19),
      .quotient(tan45)
   );

   // slide test and grip ratio
   side1_type s1_in, s1_45;

   assign s1_in = '{aneg: aneg1_ff, azero: azero1_ff, fz: fz1_ff, m: m1_ff};

   cft_delay #(.W($bits(side1_type)), .N(44)) u_dly_side1 (
      .clock(clock), .en(en), .din(s1_in), .dout(s1_45)
   );

   logic [49:0] lhs46_ff;
   logic [47:0] rhs46_ff;
   logic [45:0] zm45;
   logic [16:0] z46_ff;
   logic [18:0] fz46_ff;
   logic        aneg46_ff, azero46_ff;

   assign zm45 = z45 * s1_45.m;

   always_ff @(posedge clock) begin
      if (en) begin
         lhs46_ff   <= {46'(corner_ff * tan45), 4'd0};
         rhs46_ff   <= {1'b0, zm45, 1'b0} + {2'b0, zm45};
         z46_ff     <= z45;
         fz46_ff    <= s1_45.fz;
         aneg46_ff  <= s1_45.aneg;
         azero46_ff <= s1_45.azero;
      end
   end

   side2_type s2_in, s2_62;
   logic [15:0] y62;

   assign s2_in = '{grip: ({1'b0, 1'b0, rhs46_ff} > lhs46_ff), aneg: aneg46_ff,
                    azero: azero46_ff, z: z46_ff, zf: 36'(z46_ff * fz46_ff)};

   cft_div #(.NW(66), .DW(48), .QW(16)) u_div_grip (
      .clock(clock), .en(en), .dividend({lhs46_ff, 16'd0}), .divisor(rhs46_ff),
      .quotient(y62)
   );

   cft_delay #(.W($bits(side2_type)), .N(16)) u_dly_side2 (
      .clock(clock), .en(en), .din(s2_in), .dout(s2_62)
   );

   // fiala cubic
   logic [16:0] w62;
   logic [16:0] ww63_ff;
   logic [15:0] yy63_ff, y63_ff;
   logic [17:0] c263_ff;
   logic [21:0] slide63_ff, slide64_ff, slide65_ff, slide66_ff;
   side2_type   s63_ff, s64_ff, s65_ff;
   logic [16:0] a164_ff;
   logic [17:0] a264_ff;
   logic [29:0] b65_ff;
   logic [11:0] tp;
   logic [47:0] plo66_ff, phi66_ff;
   logic        grip66_ff, aneg66_ff, azero66_ff;
   logic [16:0] z66_ff;

   assign w62 = 17'h1_0000 - {1'b0, y62};
   assign tp  = {1'b0, mu_peak_ff, 1'b0} + {2'b0, mu_peak_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         ww63_ff    <= 17'((34'(w62) * 34'(w62)) >> 16);
         yy63_ff    <= 16'((32'(y62) * 32'(y62)) >> 16);
         y63_ff     <= y62;
         c263_ff    <= 18'd196608 - {1'b0, y62, 1'b0};
         slide63_ff <= 22'((46'(s2_62.zf) * 46'(mu_slide_ff)) >> 24);
         s63_ff     <= s2_62;
         a164_ff    <= 17'((33'(ww63_ff) * 33'(y63_ff)) >> 16);
         a264_ff    <= 18'((34'(yy63_ff) * 34'(c263_ff)) >> 16);
         slide64_ff <= slide63_ff;
         s64_ff     <= s63_ff;
         b65_ff     <= 30'(tp * a164_ff) + 30'(mu_slide_ff * a264_ff);
         slide65_ff <= slide64_ff;
         s65_ff     <= s64_ff;
         plo66_ff   <= 48'(s65_ff.zf[17:0] * b65_ff);
         phi66_ff   <= 48'(s65_ff.zf[35:18] * b65_ff);
         slide66_ff <= slide65_ff;
         grip66_ff  <= s65_ff.grip;
         aneg66_ff  <= s65_ff.aneg;
         azero66_ff <= s65_ff.azero;
         z66_ff     <= s65_ff.z;
      end
   end

   // force magnitude, saturation and sign
   logic [66:0] full66;
   logic [25:0] mag_in;
   logic [19:0] sat_in;
   logic [20:0] lat67_ff;
   logic [16:0] zeta67_ff;

   assign full66 = {1'b0, phi66_ff, 18'd0} + {19'd0, plo66_ff};
   assign mag_in = grip66_ff ? 26'(full66 >> 40) : {4'd0, slide66_ff};
   assign sat_in = (mag_in > {6'd0, FORCE_MAX}) ? FORCE_MAX : mag_in[19:0];

   always_ff @(posedge clock) begin
      if (en) begin
         priority if (azero66_ff) begin
            lat67_ff <= '0;
         end else if (aneg66_ff) begin
            lat67_ff <= {1'b0, sat_in};
         end else begin
            lat67_ff <= 21'(~{1'b0, sat_in} + 21'd1);
         end
         zeta67_ff <= z66_ff;
      end
   end

   assign rsp_tdata = {2'd0, zeta67_ff, lat67_ff};
endmodule

### hdl/cft_checker.sv
`include "coupled_fiala_tire_force_macros.svh"

module cft_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   `CFT_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result transaction changed")
   `CFT_ASSERT(a_ready_stall, !req_tready |-> rsp_tvalid && !rsp_tready, "input blocked without output stall")
   `CFT_ASSERT(a_zeta_range, rsp_tvalid |-> rsp_tdata[37:21] <= 17'd65536, "derating factor above one")
   `CFT_ASSERT(a_force_sat, rsp_tvalid |-> rsp_tdata[20:0] != 21'h100000, "lateral force not saturated")
   `CFT_ASSERT_ALWAYS(a_reset_flush, reset |=> !rsp_tvalid, "result valid after reset")
endmodule

bind coupled_fiala_tire_force cft_checker u_cft_checker (.*);

### dv/tb_top.sv
module tb_top;
   import cft_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int PIPE_DEPTH  = 68;

   typedef struct packed {
      logic [16:0] derating_factor;
      logic [20:0] lateral_force;
   } tire_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [IN_TDATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [OUT_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en;
   logic [1:0]             csr_index;
   logic [CSR_W-1:0]       csr_wdata;

   bit [63:0] stiffness_reg;
   bit [63:0] peak_mu_reg;
   bit [63:0] slide_mu_reg;

   tire_result_type pending_forces[$];
   int error_count;
   int cycle_count;
   int rsp_hold_request;

   coupled_fiala_tire_force u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] root;
      bit [63:0] b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic bit [63:0] tan_q24(bit [63:0] a);
      bit [63:0] one;
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] h;
      bit [63:0] sv;
      bit [63:0] cv;
      one = 64'd1 << 30;
      x = a << 15;
      x2 = (x * x) >> 30;
      h = one;
      for (int i = 0; i < SIN_STEPS; i++)
         h = one - ((x2 * h) >> 30) / 64'(SIN_DEN[i]);
      sv = (x * h) >> 30;
      h = one;
      for (int i = 0; i < COS_STEPS; i++)
         h = one - ((x2 * h) >> 30) / 64'(COS_DEN[i]);
      cv = (h == 0) ? 64'd1 : h;
      return (sv << 24) / cv;
   endfunction

   function automatic tire_result_type fiala_predict(logic [15:0] slip, logic [19:0] fx,
                                                     logic [18:0] fz_in);
      tire_result_type res;
      bit [63:0] amag, fxmag, fz, m, f, z, r, t, lhs, rhs, mag, y, w, a1, a2, b;
      fz = 64'(fz_in);
      amag = slip[15] ? 64'h10000 - 64'(slip) : 64'(slip);
      fxmag = fx[19] ? 64'h100000 - 64'(fx) : 64'(fx);
      m = peak_mu_reg * fz;
      f = fxmag << 8;
      z = 0;
      if (m > f) begin
         r = (f << 16) / m;
         z = int_sqrt((64'd1 << 32) - r * r);
      end
      t = tan_q24(amag);
      lhs = t * stiffness_reg * 64'd16;
      rhs = 64'd3 * z * m;
      if (lhs < rhs) begin
         y = (lhs << 16) / rhs;
         w = 64'd65536 - y;
         a1 = (((w * w) >> 16) * y) >> 16;
         a2 = (((y * y) >> 16) * (64'd196608 - 64'd2 * y)) >> 16;
         b = 64'd3 * peak_mu_reg * a1 + slide_mu_reg * a2;
         mag = (z * fz * b) >> 40;
      end else begin
         mag = (z * slide_mu_reg * fz) >> 24;
      end
      if (mag > 64'(FORCE_MAX)) mag = 64'(FORCE_MAX);
      if (amag == 0) res.lateral_force = '0;
      else if (slip[15]) res.lateral_force = mag[20:0];
      else res.lateral_force = 21'(64'd0 - mag);
      res.derating_factor = z[16:0];
      return res;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_CORNER:   stiffness_reg = 64'(value);
         REG_MU_PEAK:  peak_mu_reg = 64'(value[9:0]);
         REG_MU_SLIDE: slide_mu_reg = 64'(value[9:0]);
         default: ;
      endcase
   endtask

   task automatic csr_idle();
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_tire(logic [19:0] c, logic [19:0] p, logic [19:0] s);
      csr_write(REG_CORNER, c);
      csr_write(REG_MU_PEAK, p);
      csr_write(REG_MU_SLIDE, s);
      csr_idle();
   endtask

   task automatic send_item(logic [15:0] slip, logic [19:0] fx, logic [18:0] fz, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, fz, fx, slip};
      do @(posedge clock); while (!req_tready);
      pending_forces.push_back(fiala_predict(slip, fx, fz));
   endtask

   task automatic send_random(int gap_max);
      logic [15:0] slip;
      logic [19:0] fx;
      logic [18:0] fz;
      case ($urandom_range(0, 9))
         0: slip = 16'($urandom);
         1, 2: slip = 16'($urandom_range(0, 60));
         default: slip = 16'($urandom_range(0, 3000));
      endcase
      if ($urandom_range(0, 1)) slip = -slip;
      case ($urandom_range(0, 9))
         0: fz = 19'($urandom);
         1: fz = 19'($urandom_range(0, 200));
         default: fz = 19'($urandom_range(0, 320000));
      endcase
      case ($urandom_range(0, 9))
         0: fx = 20'($urandom);
         1: fx = 20'((peak_mu_reg * fz) >> 8);
         2: fx = 20'($urandom_range(0, 320000));
         default: fx = 20'($urandom_range(0, 100000));
      endcase
      if ($urandom_range(0, 1)) fx = -fx;
      send_item(slip, fx, fz, $urandom_range(0, gap_max));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_forces.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
   endtask

   always begin
      int stall;
      tire_result_type got;
      tire_result_type want;
      if (reset !== 1'b0) begin
         @(posedge clock);
      end else begin
         if (rsp_hold_request > 0) begin
            stall = rsp_hold_request;
            rsp_hold_request = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 5);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         got = rsp_tdata[37:0];
         if (pending_forces.size() == 0) begin
            report("unexpected transaction", 32'(got.lateral_force), 0);
         end else begin
            want = pending_forces.pop_front();
            if (got.lateral_force !== want.lateral_force)
               report("lateral_force", 32'(got.lateral_force), 32'(want.lateral_force));
            if (got.derating_factor !== want.derating_factor)
               report("derating_factor", 32'(got.derating_factor),
                      32'(want.derating_factor));
         end
      end
   end

   task automatic test_directed();
      send_item(16'sd0, 20'sd0, 19'd0, 0);
      send_item(16'sd0, 20'sd1000, 19'd320000, 1);
      send_item(16'sd32767, 20'sd0, 19'd320000, 0);
      send_item(-16'sd32768, 20'sd0, 19'd320000, 0);
      send_item(16'sd1, 20'sd0, 19'd320000, 2);
      send_item(-16'sd1, 20'sd0, 19'd320000, 0);
      send_item(16'sd100, 20'sd320000, 19'd320000, 0);
      send_item(16'sd100, -20'sd320000, 19'd320000, 0);
      send_item(16'sd100, 20'sd320000, 19'd1000, 0);
      send_item(16'sd100, 20'sd1000, 19'd1000, 0);
      send_item(16'sd100, 20'h7FFFF, 19'h7FFFF, 3);
      send_item(16'sd100, 20'h80000, 19'h7FFFF, 0);
      send_item(-16'sd200, 20'sd0, 19'h7FFFF, 0);
      send_item(16'sd5, 20'sd0, 19'd320000, 0);
      send_item(16'hFFFF, 20'hFFFFF, 19'd1, 0);
      drain();
      set_tire(20'd0, 20'd512, 20'd0);
      send_item(16'sd500, 20'sd0, 19'd320000, 0);
      send_item(-16'sd500, 20'sd100, 19'd320000, 0);
      drain();
      set_tire(20'hFFFFF, 20'd0, 20'd512);
      send_item(16'sd500, 20'sd0, 19'd320000, 0);
      send_item(16'sd32767, 20'sd0, 19'h7FFFF, 0);
      drain();
      set_tire(20'd1, 20'h3FF, 20'h3FF);
      send_item(16'sd32767, 20'sd0, 19'h7FFFF, 0);
      send_item(-16'sd32768, 20'sd0, 19'h7FFFF, 0);
      send_item(16'sd3, 20'sd0, 19'h7FFFF, 0);
      drain();
   endtask

   task automatic test_register_sweep();
      logic [19:0] settings [8][3] = '{
         '{20'd100000, 20'd256, 20'd256},
         '{20'd1, 20'd0, 20'd0},
         '{20'd1048575, 20'd512, 20'd512},
         '{20'd0, 20'd256, 20'd200},
         '{20'd20000, 20'd300, 20'd100},
         '{20'd500000, 20'd64, 20'd512},
         '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF},
         '{20'd80000, 20'd220, 20'd180}
      };
      foreach (settings[i]) begin
         set_tire(settings[i][0], settings[i][1], settings[i][2]);
         repeat (60) send_random(5);
         drain();
      end
      csr_write(reg_index_type'(2'd3), 20'd12345);
      csr_idle();
      repeat (20) send_random(2);
      drain();
   endtask

   task automatic test_backpressure();
      set_tire(20'd100000, 20'd256, 20'd256);
      rsp_hold_request = 400;
      repeat (200) send_random(0);
      drain();
   endtask

   task automatic test_random();
      for (int n = 0; n < 1200; n++) begin
         if (n % 300 == 0) begin
            drain();
            set_tire(20'($urandom_range(1, 1048575)), 20'($urandom_range(0, 512)),
                     20'($urandom_range(0, 512)));
         end
         if ((n / 100) % 3 == 2) send_random(0);
         else send_random(5);
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      error_count = 0;
      cycle_count = 0;
      rsp_hold_request = 0;
      stiffness_reg = 64'(CORNER_RESET);
      peak_mu_reg = 64'(MU_PEAK_RESET);
      slide_mu_reg = 64'(MU_SLIDE_RESET);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_sweep();
      test_backpressure();
      test_random();
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
